>>> design/gvng_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvng_pkg: shared types and tables of the grid vertex neighbor generator
// case key decoding, neighbor step tables and controller/datapath links
// ----------------------------------------------------------------------------
package gvng_pkg;

   localparam int IDX_W         = 30;
   localparam int MAX_NEIGHBORS = 14;
   localparam int CASE_COUNT    = 64;
   localparam int SLOT_W        = 4;
   localparam int KEY_W         = $clog2(CASE_COUNT);
   localparam int STEP_W        = $clog2(IDX_W + 1);

   // register indexes of the write port
   localparam logic [1:0] CSR_DIM_X = 2'd0;
   localparam logic [1:0] CSR_DIM_Y = 2'd1;
   localparam logic [1:0] CSR_DIM_Z = 2'd2;

   // face bits of the case key
   localparam logic [KEY_W-1:0] FACE_X_LO = 6'd1;
   localparam logic [KEY_W-1:0] FACE_X_HI = 6'd2;
   localparam logic [KEY_W-1:0] FACE_Y_LO = 6'd4;
   localparam logic [KEY_W-1:0] FACE_Y_HI = 6'd8;
   localparam logic [KEY_W-1:0] FACE_Z_LO = 6'd16;
   localparam logic [KEY_W-1:0] FACE_Z_HI = 6'd32;

   typedef enum logic [1:0] {
      STEP_ZERO,
      STEP_PLUS,
      STEP_MINUS
   } step_dir_type;

   typedef struct packed {
      step_dir_type sx;
      step_dir_type sy;
      step_dir_type sz;
   } step_type;

   // slot 0 is the leftmost nibble
   typedef logic [0:MAX_NEIGHBORS-1][3:0] pick_row_type;

   typedef struct packed {
      logic capture;
      logic plane;
      logic div_z_go;
      logic div_y_go;
      logic key;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic count_zero;
      logic last_slot;
      logic out_stall;
   } status_type;

   function automatic logic [SLOT_W-1:0] count_rom(input logic [KEY_W-1:0] key);
      logic [SLOT_W-1:0] c;
      case (key)
         6'd0:    c = 4'd14;
         6'd1:    c = 4'd10;
         6'd2:    c = 4'd10;
         6'd4:    c = 4'd10;
         6'd5:    c = 4'd6;
         6'd6:    c = 4'd8;
         6'd8:    c = 4'd10;
         6'd9:    c = 4'd8;
         6'd10:   c = 4'd6;
         6'd16:   c = 4'd10;
         6'd17:   c = 4'd6;
         6'd18:   c = 4'd8;
         6'd20:   c = 4'd8;
         6'd21:   c = 4'd4;
         6'd22:   c = 4'd7;
         6'd24:   c = 4'd6;
         6'd25:   c = 4'd4;
         6'd26:   c = 4'd4;
         6'd32:   c = 4'd10;
         6'd33:   c = 4'd8;
         6'd34:   c = 4'd6;
         6'd36:   c = 4'd6;
         6'd37:   c = 4'd4;
         6'd38:   c = 4'd4;
         6'd40:   c = 4'd8;
         6'd41:   c = 4'd7;
         6'd42:   c = 4'd4;
         default: c = 4'd0;
      endcase
      return c;
   endfunction

   function automatic pick_row_type pick_rom(input logic [KEY_W-1:0] key);
      pick_row_type p;
      case (key)
         6'd0:    p = 56'h0123456789ABCD;
         6'd1:    p = 56'h0123456BD80000;
         6'd2:    p = 56'h9AB78CD2040000;
         6'd4:    p = 56'h9AB78CD6320000;
         6'd5:    p = 56'h6B8D2300000000;
         6'd6:    p = 56'h9AB78CD2000000;
         6'd8:    p = 56'h01234569780000;
         6'd9:    p = 56'h01234568000000;
         6'd10:   p = 56'h49780200000000;
         6'd16:   p = 56'h9AB78CD4560000;
         6'd17:   p = 56'h4568BD00000000;
         6'd18:   p = 56'h9AB78CD4000000;
         6'd20:   p = 56'h9AB78CD6000000;
         6'd21:   p = 56'h6B8D0000000000;
         6'd22:   p = 56'h9AB78CD0000000;
         6'd24:   p = 56'h49785600000000;
         6'd25:   p = 56'h45680000000000;
         6'd26:   p = 56'h49780000000000;
         6'd32:   p = 56'h01234569AB0000;
         6'd33:   p = 56'h0123456B000000;
         6'd34:   p = 56'h29AB0400000000;
         6'd36:   p = 56'h29AB3600000000;
         6'd37:   p = 56'h236B0000000000;
         6'd38:   p = 56'h29AB0000000000;
         6'd40:   p = 56'h01234569000000;
         6'd41:   p = 56'h01234560000000;
         6'd42:   p = 56'h02490000000000;
         default: p = '0;
      endcase
      return p;
   endfunction

   // full neighbor set of an interior vertex, as (dx, dy, dz)
   function automatic step_type step_rom(input logic [3:0] sel);
      step_type s;
      case (sel)
         4'd0:    s = '{STEP_ZERO,  STEP_MINUS, STEP_MINUS};
         4'd1:    s = '{STEP_PLUS,  STEP_MINUS, STEP_MINUS};
         4'd2:    s = '{STEP_ZERO,  STEP_ZERO,  STEP_MINUS};
         4'd3:    s = '{STEP_PLUS,  STEP_ZERO,  STEP_MINUS};
         4'd4:    s = '{STEP_ZERO,  STEP_MINUS, STEP_ZERO};
         4'd5:    s = '{STEP_PLUS,  STEP_MINUS, STEP_ZERO};
         4'd6:    s = '{STEP_PLUS,  STEP_ZERO,  STEP_ZERO};
         4'd7:    s = '{STEP_MINUS, STEP_ZERO,  STEP_PLUS};
         4'd8:    s = '{STEP_ZERO,  STEP_ZERO,  STEP_PLUS};
         4'd9:    s = '{STEP_MINUS, STEP_ZERO,  STEP_ZERO};
         4'd10:   s = '{STEP_MINUS, STEP_PLUS,  STEP_ZERO};
         4'd11:   s = '{STEP_ZERO,  STEP_PLUS,  STEP_ZERO};
         4'd12:   s = '{STEP_MINUS, STEP_PLUS,  STEP_PLUS};
         4'd13:   s = '{STEP_ZERO,  STEP_PLUS,  STEP_PLUS};
         default: s = '{STEP_ZERO,  STEP_ZERO,  STEP_ZERO};
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

>>> design/gvng_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvng_divider: bit-serial restoring divider
// one quotient bit per cycle, start remainder and step count set by the caller
// ----------------------------------------------------------------------------
module gvng_divider #(
   parameter int DEN_W = 22
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [gvng_pkg::IDX_W-1:0]    start_num,
   input  wire logic [DEN_W-1:0]              start_den,
   input  wire logic [DEN_W-1:0]              start_rem,
   input  wire logic [gvng_pkg::STEP_W-1:0]   start_steps,
   output logic      [gvng_pkg::IDX_W-1:0]    quot,
   output logic      [DEN_W-1:0]              rem,
   output logic                               done
);

   localparam int IW = gvng_pkg::IDX_W;

   logic [IW-1:0]               num_ff;
   logic [IW-1:0]               quot_ff;
   logic [DEN_W-1:0]            rem_ff;
   logic [DEN_W-1:0]            den_ff;
   logic [gvng_pkg::STEP_W-1:0] cnt_ff;
   logic                        busy_ff;
   logic                        done_ff;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;
   logic [DEN_W-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff, num_ff[IW-1]};
      diff   = trial - {1'b0, den_ff};
      fits   = (trial >= {1'b0, den_ff});
      rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == gvng_pkg::STEP_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= start_num;
         den_ff  <= start_den;
         rem_ff  <= start_rem;
         cnt_ff  <= start_steps;
         quot_ff <= '0;
      end else if (busy_ff) begin
         num_ff  <= {num_ff[IW-2:0], 1'b0};
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[IW-2:0], fits};
         cnt_ff  <= cnt_ff - gvng_pkg::STEP_W'(1);
      end
   end

   assign quot = quot_ff;
   assign rem  = rem_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

>>> design/gvng_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvng_datapath: size registers, index split, case key and neighbor output
// works under commands of the controller, result register on the output side
// ----------------------------------------------------------------------------
module gvng_datapath #(
   parameter int AXIS_BITS = 10
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [1:0]                 csr_addr,
   input  wire logic [AXIS_BITS:0]         csr_wdata,
   input  wire logic [gvng_pkg::IDX_W-1:0] vertex_index,
   input  wire gvng_pkg::cmd_type          cmd,
   output gvng_pkg::status_type            status,
   input  wire logic                       rsp_tready,
   output logic                            rsp_tvalid,
   output logic [39:0]                     rsp_tdata,
   output logic                            rsp_tlast
);

   localparam int IW = gvng_pkg::IDX_W;
   localparam int SW = gvng_pkg::SLOT_W;
   localparam int KW = gvng_pkg::KEY_W;
   localparam int DW = AXIS_BITS + 1;
   localparam int PW = 2 * DW;

   function automatic logic [IW-1:0] term(input gvng_pkg::step_dir_type d,
                                          input logic [IW-1:0] v);
      logic [IW-1:0] t;
      case (d)
         gvng_pkg::STEP_PLUS:  t = v;
         gvng_pkg::STEP_MINUS: t = IW'(0) - v;
         default:              t = '0;
      endcase
      return t;
   endfunction

   logic [DW-1:0] dim_x_ff, dim_y_ff, dim_z_ff;
   logic [DW-1:0] ex, ey, ez;
   logic [IW-1:0] idx_ff;
   logic [PW-1:0] plane_ff;
   logic [IW-1:0] z_ff;
   logic [KW-1:0] key_ff;
   logic [SW-1:0] count_ff;
   logic [SW-1:0] slot_ff;

   logic          rsp_valid_ff;
   logic [IW-1:0] nb_index_ff;
   logic [SW-1:0] nb_slot_ff;
   logic [SW-1:0] nb_count_ff;
   logic          nb_last_ff;

   logic                        div_start;
   logic [IW-1:0]               div_num;
   logic [PW-1:0]               div_den;
   logic [PW-1:0]               div_rem0;
   logic [gvng_pkg::STEP_W-1:0] div_steps;
   logic [IW-1:0]               div_quot;
   logic [PW-1:0]               div_rem;
   logic                        div_done;

   logic [KW-1:0]          key_in;
   logic [DW-1:0]          y_val;
   logic                   last_slot;
   gvng_pkg::pick_row_type pick_row;
   gvng_pkg::step_type     step;
   logic [IW-1:0]          nb_index_in;

   // a size of zero counts as one
   assign ex = (dim_x_ff == '0) ? DW'(1) : dim_x_ff;
   assign ey = (dim_y_ff == '0) ? DW'(1) : dim_y_ff;
   assign ez = (dim_z_ff == '0) ? DW'(1) : dim_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff <= DW'(2);
         dim_y_ff <= DW'(2);
         dim_z_ff <= DW'(2);
      end else if (csr_we) begin
         unique case (csr_addr)
            gvng_pkg::CSR_DIM_X: dim_x_ff <= csr_wdata;
            gvng_pkg::CSR_DIM_Y: dim_y_ff <= csr_wdata;
            gvng_pkg::CSR_DIM_Z: dim_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // first pass: index by plane, second pass: remainder by row length,
   // the second starts with the upper remainder bits already shifted in
   always_comb begin
      div_start = cmd.div_z_go | cmd.div_y_go;
      if (cmd.div_y_go) begin
         div_num   = IW'(div_rem[DW-1:0]) << (IW - DW);
         div_den   = PW'(ex);
         div_rem0  = div_rem >> DW;
         div_steps = gvng_pkg::STEP_W'(DW);
      end else begin
         div_num   = idx_ff;
         div_den   = plane_ff;
         div_rem0  = '0;
         div_steps = gvng_pkg::STEP_W'(IW);
      end
   end

   gvng_divider #(
      .DEN_W (PW)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .start_num   (div_num),
      .start_den   (div_den),
      .start_rem   (div_rem0),
      .start_steps (div_steps),
      .quot        (div_quot),
      .rem         (div_rem),
      .done        (div_done)
   );

   always_comb begin
      y_val  = div_quot[DW-1:0];
      key_in = '0;
      if (div_rem == '0) begin
         key_in = key_in | gvng_pkg::FACE_X_LO;
      end else if (div_rem == PW'(ex - DW'(1))) begin
         key_in = key_in | gvng_pkg::FACE_X_HI;
      end
      if (y_val == '0) begin
         key_in = key_in | gvng_pkg::FACE_Y_LO;
      end else if (y_val == ey - DW'(1)) begin
         key_in = key_in | gvng_pkg::FACE_Y_HI;
      end
      if (z_ff == '0) begin
         key_in = key_in | gvng_pkg::FACE_Z_LO;
      end else if (z_ff == IW'(ez - DW'(1))) begin
         key_in = key_in | gvng_pkg::FACE_Z_HI;
      end
   end

   always_comb begin
      pick_row    = gvng_pkg::pick_rom(key_ff);
      step        = gvng_pkg::step_rom(pick_row[slot_ff]);
      nb_index_in = idx_ff + term(step.sx, IW'(1)) + term(step.sy, IW'(ex))
                    + term(step.sz, IW'(plane_ff));
      last_slot   = (SW'(slot_ff + SW'(1)) == count_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff <= vertex_index;
      end
      if (cmd.plane) begin
         plane_ff <= PW'(ex) * PW'(ey);
      end
      if (cmd.div_y_go) begin
         z_ff <= div_quot;
      end
      if (cmd.key) begin
         key_ff   <= key_in;
         count_ff <= gvng_pkg::count_rom(key_in);
         slot_ff  <= '0;
      end else if (cmd.emit) begin
         slot_ff  <= slot_ff + SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         nb_index_ff <= nb_index_in;
         nb_slot_ff  <= slot_ff;
         nb_count_ff <= count_ff;
         nb_last_ff  <= last_slot;
      end
   end

   assign status.div_done   = div_done;
   assign status.count_zero = (count_ff == '0);
   assign status.last_slot  = last_slot;
   assign status.out_stall  = rsp_valid_ff & ~rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, nb_count_ff, nb_slot_ff, nb_index_ff};
   assign rsp_tlast  = nb_last_ff;

endmodule
`default_nettype wire

>>> design/gvng_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvng_ctrl: sequencer of the neighbor generator
// steps one vertex through plane product, two divisions, key and emission
// ----------------------------------------------------------------------------
module gvng_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire gvng_pkg::status_type status,
   output gvng_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PLANE,
      S_ZGO,
      S_ZWAIT,
      S_YGO,
      S_YWAIT,
      S_KEY,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = S_PLANE;
            end
         end
         S_PLANE: begin
            cmd.plane = 1'b1;
            state_in  = S_ZGO;
         end
         S_ZGO: begin
            cmd.div_z_go = 1'b1;
            state_in     = S_ZWAIT;
         end
         S_ZWAIT: begin
            if (status.div_done) begin
               state_in = S_YGO;
            end
         end
         S_YGO: begin
            cmd.div_y_go = 1'b1;
            state_in     = S_YWAIT;
         end
         S_YWAIT: begin
            if (status.div_done) begin
               state_in = S_KEY;
            end
         end
         S_KEY: begin
            cmd.key  = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.count_zero) begin
               state_in = S_IDLE;
            end else if (!status.out_stall) begin
               cmd.emit = 1'b1;
               if (status.last_slot) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule
`default_nettype wire

>>> design/grid_vertex_neighbor_gen.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_vertex_neighbor_gen: vertex neighbors of an implicit 3d regular grid
// splits a linear vertex index into x, y, z and emits its Freudenthal neighbors
// ----------------------------------------------------------------------------
// One vertex is handled at a time. After a req transfer the block registers the
// plane product, splits the index with a shared bit-serial divider (the 30
// quotient bits of z first, then AXIS_BITS+1 bits for y), registers the
// boundary case key and then sends one rsp transfer per neighbor, one per
// cycle while rsp_tready is high. A new vertex is taken while the final
// neighbor still waits in the output register. The user must write the sizes
// through csr_* only while the block is idle; the block does not enforce it.
// A size of zero acts as one and indices beyond the grid are not checked
// (results wrap modulo 2^30).
// ----------------------------------------------------------------------------
module grid_vertex_neighbor_gen #(
   parameter int AXIS_BITS = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // configuration writes, index 0 dim_x, 1 dim_y, 2 dim_z
   input  wire logic                 csr_we,
   input  wire logic [1:0]           csr_addr,
   input  wire logic [AXIS_BITS:0]   csr_wdata,
   // vertex input
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [31:0]          req_tdata,   // [29:0] vertex_index
   // neighbor output
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [39:0]               rsp_tdata,   // [29:0] neighbor_index,
                                                  // [33:30] neighbor_slot,
                                                  // [37:34] neighbor_count
   output logic                      rsp_tlast    // last neighbor of the vertex
);

   // control and status between sequencer and datapath
   gvng_pkg::cmd_type    cmd;
   gvng_pkg::status_type status;

   // sequencer: one vertex in flight, ready only when idle
   gvng_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: size registers, divider, case tables, result register
   gvng_datapath #(
      .AXIS_BITS (AXIS_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .vertex_index (req_tdata[gvng_pkg::IDX_W-1:0]),
      .cmd          (cmd),
      .status       (status),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
`default_nettype wire

>>> design/gvng_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvng_checker: port-level checks of the neighbor generator
// watches the req and rsp channels of the top level
// ----------------------------------------------------------------------------
module gvng_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // slot stays inside the neighbor list
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33:30] < rsp_tdata[37:34])
      else $error("neighbor slot beyond count");

   // last marks exactly the final slot
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (4'(rsp_tdata[33:30] + 4'd1) == rsp_tdata[37:34])))
      else $error("last flag does not match slot");

   // one vertex at a time: busy after a req transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken twice in a row");

endmodule

bind grid_vertex_neighbor_gen gvng_checker u_checker (.*);
`default_nettype wire

>>> tb/grid_vertex_neighbor_gen_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_vertex_neighbor_gen_tb: self-checking bench of the grid neighbor generator
// drives vertex indices under several grid sizes, predicts each vertex's
// neighbor list in the bench and compares every rsp transfer against it,
// with random idling on both streams and forced back-pressure
// ----------------------------------------------------------------------------
module grid_vertex_neighbor_gen_tb;

   localparam int AXIS_BITS       = 10;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int TAIL_CYCLES     = 80;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 55;
   localparam int REPORT_LIMIT    = 10;
   localparam int DIRECTED_ROWS   = 25;

   // write index with no register behind it, writes there must be dropped
   localparam logic [1:0] CSR_UNUSED   = 2'd3;
   // case key of a vertex that touches no face
   localparam logic [5:0] KEY_INTERIOR = 6'd0;

   typedef enum logic {
      ROW_SIZE,
      ROW_VERTEX
   } row_kind_type;

   // one row of the directed table; want_* only hold where typed is set
   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   addr;
      logic [29:0]  value;
      logic         typed;
      logic [3:0]   want_count;
      logic [29:0]  want_first;
   } stim_row_type;

   typedef struct packed {
      logic [29:0] index;
      logic [3:0]  slot;
      logic [3:0]  count;
      logic        last;
   } neighbor_type;

   // ---------------------------------------------------------------------
   // dut hookup
   // ---------------------------------------------------------------------
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 csr_we     = 1'b0;
   logic [1:0]           csr_addr   = gvng_pkg::CSR_DIM_X;
   logic [AXIS_BITS:0]   csr_wdata  = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata  = '0;   // [29:0] vertex_index
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [39:0]          rsp_tdata;         // [29:0] neighbor_index, [33:30] neighbor_slot,
                                            // [37:34] neighbor_count
   logic                 rsp_tlast;

   grid_vertex_neighbor_gen #(
      .AXIS_BITS(AXIS_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // bench-side copy of the grid sizes and the neighbor predictor
   // ---------------------------------------------------------------------
   logic [AXIS_BITS:0] size_x = 11'd2;
   logic [AXIS_BITS:0] size_y = 11'd2;
   logic [AXIS_BITS:0] size_z = 11'd2;

   neighbor_type neighbors_due [$];     // expected rsp transfers, oldest first
   neighbor_type next_neighbors [14];   // staging for the vertex being sent
   logic [63:0] keys_seen = '0;

   int req_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   int hold_requests = 0;
   int errors        = 0;
   int vertices_sent = 0;
   int neighbors_checked = 0;
   int size_writes   = 0;
   int cycle_count   = 0;

   // Freudenthal steps as (dx, dy, dz) signs, full interior list order
   string step_moves [14] = '{"0--", "+--", "00-", "+0-", "0-0", "+-0", "+00",
                              "-0+", "00+", "-00", "-+0", "0+0", "-++", "0++"};

   // per boundary case: which steps, in emission order; length is the count
   function automatic string neighbor_order(input logic [5:0] key);
      case (key)
         KEY_INTERIOR:
            return "0123456789abcd";
         gvng_pkg::FACE_X_LO:
            return "0123456bd8";
         gvng_pkg::FACE_X_HI:
            return "9ab78cd204";
         gvng_pkg::FACE_Y_LO:
            return "9ab78cd632";
         gvng_pkg::FACE_X_LO | gvng_pkg::FACE_Y_LO:
            return "6b8d23";
         gvng_pkg::FACE_X_HI | gvng_pkg::FACE_Y_LO:
            return "9ab78cd2";
         gvng_pkg::FACE_Y_HI:
            return "0123456978";
         gvng_pkg::FACE_X_LO | gvng_pkg::FACE_Y_HI:
            return "01234568";
         gvng_pkg::FACE_X_HI | gvng_pkg::FACE_Y_HI:
            return "497802";
         gvng_pkg::FACE_Z_LO:
            return "9ab78cd456";
         gvng_pkg::FACE_X_LO | gvng_pkg::FACE_Z_LO:
            return "4568bd";
         gvng_pkg::FACE_X_HI | gvng_pkg::FACE_Z_LO:
            return "9ab78cd4";
         gvng_pkg::FACE_Y_LO | gvng_pkg::FACE_Z_LO:
            return "9ab78cd6";
         gvng_pkg::FACE_X_LO | gvng_pkg::FACE_Y_LO | gvng_pkg::FACE_Z_LO:
            return "6b8d";
         gvng_pkg::FACE_X_HI | gvng_pkg::FACE_Y_LO | gvng_pkg::FACE_Z_LO:
            return "9ab78cd";
         gvng_pkg::FACE_Y_HI | gvng_pkg::FACE_Z_LO:
            return "497856";
         gvng_pkg::FACE_X_LO | gvng_pkg::FACE_Y_HI | gvng_pkg::FACE_Z_LO:
            return "4568";
         gvng_pkg::FACE_X_HI | gvng_pkg::FACE_Y_HI | gvng_pkg::FACE_Z_LO:
            return "4978";
         gvng_pkg::FACE_Z_HI:
            return "01234569ab";
         gvng_pkg::FACE_X_LO | gvng_pkg::FACE_Z_HI:
            return "0123456b";
         gvng_pkg::FACE_X_HI | gvng_pkg::FACE_Z_HI:
            return "29ab04";
         gvng_pkg::FACE_Y_LO | gvng_pkg::FACE_Z_HI:
            return "29ab36";
         gvng_pkg::FACE_X_LO | gvng_pkg::FACE_Y_LO | gvng_pkg::FACE_Z_HI:
            return "236b";
         gvng_pkg::FACE_X_HI | gvng_pkg::FACE_Y_LO | gvng_pkg::FACE_Z_HI:
            return "29ab";
         gvng_pkg::FACE_Y_HI | gvng_pkg::FACE_Z_HI:
            return "01234569";
         gvng_pkg::FACE_X_LO | gvng_pkg::FACE_Y_HI | gvng_pkg::FACE_Z_HI:
            return "0123456";
         gvng_pkg::FACE_X_HI | gvng_pkg::FACE_Y_HI | gvng_pkg::FACE_Z_HI:
            return "0249";
         default:
            return "";
      endcase
   endfunction

   function automatic int hex_digit(input byte c);
      return (c >= "a") ? c - "a" + 10 : c - "0";
   endfunction

   function automatic longint axis_step(input byte c);
      return (c == "+") ? 1 : (c == "-") ? -1 : 0;
   endfunction

   // a size of zero behaves as one
   function automatic longint eff_size(input logic [AXIS_BITS:0] s);
      return (s == 0) ? 1 : longint'(s);
   endfunction

   // low face wins when the axis is one vertex long
   function automatic logic [5:0] face_of(input longint c, input longint d,
                                          input logic [5:0] lo, input logic [5:0] hi);
      if (c == 0) return lo;
      if (c == d - 1) return hi;
      return '0;
   endfunction

   // fills next_neighbors for one vertex, returns how many there are
   function automatic int predict_neighbors(input logic [29:0] v);
      longint idx, sx, sy, sz, plane, cx, cy, cz, rem, n;
      logic [5:0] key;
      string order;
      string mv;
      idx   = v;
      sx    = eff_size(size_x);
      sy    = eff_size(size_y);
      sz    = eff_size(size_z);
      plane = sx * sy;
      cz    = idx / plane;
      rem   = idx - cz * plane;
      cy    = rem / sx;
      cx    = rem % sx;
      key   = face_of(cx, sx, gvng_pkg::FACE_X_LO, gvng_pkg::FACE_X_HI) |
              face_of(cy, sy, gvng_pkg::FACE_Y_LO, gvng_pkg::FACE_Y_HI) |
              face_of(cz, sz, gvng_pkg::FACE_Z_LO, gvng_pkg::FACE_Z_HI);
      keys_seen[key] = 1'b1;
      order = neighbor_order(key);
      for (int k = 0; k < order.len(); k++) begin
         mv = step_moves[hex_digit(order[k])];
         // beyond-grid indices simply wrap, only the low 30 bits survive
         n  = idx + axis_step(mv[0]) + axis_step(mv[1]) * sx + axis_step(mv[2]) * plane;
         next_neighbors[k].index = n[29:0];
         next_neighbors[k].slot  = 4'(k);
         next_neighbors[k].count = 4'(order.len());
         next_neighbors[k].last  = (k == order.len() - 1);
      end
      return order.len();
   endfunction

   // ---------------------------------------------------------------------
   // random stimulus shaping
   // ---------------------------------------------------------------------
   // mostly small grids so faces come up often, now and then huge, degenerate
   // or beyond the nominal range of the register
   function automatic logic [AXIS_BITS:0] pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 11'($urandom_range(6, 2));
      if (r < 75) return 11'($urandom_range(40, 7));
      if (r < 85) return 11'($urandom_range(1024, 41));
      if (r < 93) return 11'($urandom_range(1, 0));
      return 11'($urandom_range(2047, 1025));
   endfunction

   function automatic longint pick_coord(input longint d);
      int r;
      r = $urandom_range(2);
      if (r == 0) return 0;
      if (r == 1) return d - 1;
      return $urandom_range(32'(d - 1), 0);
   endfunction

   // face-biased vertex inside the grid, or a raw 30-bit index now and then
   function automatic logic [29:0] pick_vertex();
      longint sx, sy, v;
      if ($urandom_range(99) < 10) return 30'($urandom);
      sx = eff_size(size_x);
      sy = eff_size(size_y);
      v  = pick_coord(eff_size(size_z)) * sx * sy + pick_coord(sy) * sx + pick_coord(sx);
      return v[29:0];
   endfunction

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------
   // offer one vertex, wait for its transfer, then queue its neighbor list;
   // a typed row overrides the count and first index with hand-worked values
   task automatic send_vertex(input logic [29:0] v, input logic typed,
                              input logic [3:0] want_count, input logic [29:0] want_first);
      int n;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, v};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n = predict_neighbors(v);
      for (int k = 0; k < n; k++) begin
         if (typed) begin
            next_neighbors[k].count = want_count;
            if (k == 0) next_neighbors[k].index = want_first;
         end
         neighbors_due.push_back(next_neighbors[k]);
      end
      vertices_sent++;
   endtask

   // stop offering and wait until every queued neighbor has come out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (neighbors_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write, after which the write port goes quiet again
   task automatic write_size(input logic [1:0] addr, input logic [AXIS_BITS:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      case (addr)
         gvng_pkg::CSR_DIM_X: size_x = value;
         gvng_pkg::CSR_DIM_Y: size_y = value;
         gvng_pkg::CSR_DIM_Z: size_z = value;
         default: ;
      endcase
      size_writes++;
   endtask

   task automatic set_sizes(input logic [AXIS_BITS:0] x, input logic [AXIS_BITS:0] y,
                            input logic [AXIS_BITS:0] z);
      write_size(gvng_pkg::CSR_DIM_X, x);
      write_size(gvng_pkg::CSR_DIM_Y, y);
      write_size(gvng_pkg::CSR_DIM_Z, z);
   endtask

   // ---------------------------------------------------------------------
   // rsp side: random ready, plus a long hold-off when the main flow asks
   // ---------------------------------------------------------------------
   int hold_served = 0;
   int hold_left   = 0;

   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = RSP_HOLD_CYCLES;
      end
      if (reset || hold_left != 0) begin
         rsp_tready <= 1'b0;
         if (hold_left != 0) hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // checker: every rsp transfer against the oldest queued neighbor
   always @(posedge clock) begin
      neighbor_type got;
      neighbor_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.index = rsp_tdata[29:0];
         got.slot  = rsp_tdata[33:30];
         got.count = rsp_tdata[37:34];
         got.last  = rsp_tlast;
         if (neighbors_due.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected neighbor transfer: idx %0d slot %0d count %0d last %0d",
                        got.index, got.slot, got.count, got.last);
         end else begin
            want = neighbors_due.pop_front();
            neighbors_checked++;
            if (got !== want) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("neighbor mismatch: want idx %0d slot %0d count %0d last %0d, %s",
                           want.index, want.slot, want.count, want.last,
                           $sformatf("got idx %0d slot %0d count %0d last %0d",
                                     got.index, got.slot, got.count, got.last));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("grid_vertex_neighbor_gen verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // directed table: sizes at the extremes, corner vertices, dropped write,
   // zero and one sizes, indices past the grid and wrap at 2^30
   // ---------------------------------------------------------------------
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // reset grid 2x2x2: origin corner and the far corner
      '{ROW_VERTEX, gvng_pkg::CSR_DIM_X, 30'd0,          1'b1, 4'd4,  30'd1},
      '{ROW_VERTEX, gvng_pkg::CSR_DIM_X, 30'd7,          1'b1, 4'd4,  30'd1},
      '{ROW_VERTEX, gvng_pkg::CSR_DIM_X, 30'd3,          1'b0, 4'd0,  30'd0},
      // largest grid, 1024 per axis, fills the whole index range
      '{ROW_SIZE,   gvng_pkg::CSR_DIM_X, 30'd1024,       1'b0, 4'd0,  30'd0},
      '{ROW_SIZE,   gvng_pkg::CSR_DIM_Y, 30'd1024,       1'b0, 4'd0,  30'd0},
      '{ROW_SIZE,   gvng_pkg::CSR_DIM_Z, 30'd1024,       1'b0, 4'd0,  30'd0},
      '{ROW_VERTEX, gvng_pkg::CSR_DIM_X, 30'h3FFFFFFF,   1'b1, 4'd4,  30'd1072692223},
      '{ROW_VERTEX, gvng_pkg::CSR_DIM_X, 30'd0,          1'b1, 4'd4,  30'd1},
      '{ROW_VERTEX, gvng_pkg::CSR_DIM_X, 30'd5250051,    1'b0, 4'd0,  30'd0},
      '{ROW_VERTEX, gvng_pkg::CSR_DIM_X, 30'd1023,       1'b0, 4'd0,  30'd0},
      '{ROW_VERTEX, gvng_pkg::CSR_DIM_X, 30'd1048575,    1'b0, 4'd0,  30'd0},
      // write to an index with no register, must leave the sizes alone
      '{ROW_SIZE,   CSR_UNUSED,          30'd5,          1'b0, 4'd0,  30'd0},
      '{ROW_VERTEX, gvng_pkg::CSR_DIM_X, 30'd1072693248, 1'b0, 4'd0,  30'd0},
      // zero size acts as one
      '{ROW_SIZE,   gvng_pkg::CSR_DIM_X, 30'd0,          1'b0, 4'd0,  30'd0},
      '{ROW_VERTEX, gvng_pkg::CSR_DIM_X, 30'd0,          1'b1, 4'd4,  30'd1},
      // one-vertex axes: low face only, z runs past the grid unchecked
      '{ROW_SIZE,   gvng_pkg::CSR_DIM_Y, 30'd1,          1'b0, 4'd0,  30'd0},
      '{ROW_SIZE,   gvng_pkg::CSR_DIM_Z, 30'd1,          1'b0, 4'd0,  30'd0},
      '{ROW_VERTEX, gvng_pkg::CSR_DIM_X, 30'd5000,       1'b1, 4'd6,  30'd5001},
      '{ROW_VERTEX, gvng_pkg::CSR_DIM_X, 30'h3FFFFFFF,   1'b1, 4'd6,  30'd0},
      // 3x3x3 center vertex has the full set of fourteen
      '{ROW_SIZE,   gvng_pkg::CSR_DIM_X, 30'd3,          1'b0, 4'd0,  30'd0},
      '{ROW_SIZE,   gvng_pkg::CSR_DIM_Y, 30'd3,          1'b0, 4'd0,  30'd0},
      '{ROW_SIZE,   gvng_pkg::CSR_DIM_Z, 30'd3,          1'b0, 4'd0,  30'd0},
      '{ROW_VERTEX, gvng_pkg::CSR_DIM_X, 30'd13,         1'b1, 4'd14, 30'd1},
      // all register bits set, past the nominal size range
      '{ROW_SIZE,   gvng_pkg::CSR_DIM_X, 30'd2047,       1'b0, 4'd0,  30'd0},
      '{ROW_VERTEX, gvng_pkg::CSR_DIM_X, 30'd2046,       1'b0, 4'd0,  30'd0}
   };

   // ---------------------------------------------------------------------
   // main flow
   // ---------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 30;
      rsp_idle_pct = 30;
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_SIZE) begin
            drain_results();
            write_size(directed_rows[r].addr, directed_rows[r].value[AXIS_BITS:0]);
         end else begin
            send_vertex(directed_rows[r].value, directed_rows[r].typed,
                        directed_rows[r].want_count, directed_rows[r].want_first);
         end
      end

      // random phases: sizes change only while the block is empty
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_results();
         if (p < 2) begin
            req_idle_pct = 11;
            rsp_idle_pct = 63;
         end else if (p < 4) begin
            req_idle_pct = 63;
            rsp_idle_pct = 11;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (p == 0) begin
            set_sizes(11'd2, 11'd2, 11'd2);
         end else if (p == RANDOM_PHASES - 1) begin
            set_sizes(11'd1024, 11'd1024, 11'd1024);
         end else begin
            set_sizes(pick_size(), pick_size(), pick_size());
         end
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // long rsp stall while vertices keep coming, so req backs up
            if (p == 1 && i == 20) hold_requests++;
            // sender goes quiet until the pipe is empty
            if (p == 3 && i == 30) drain_results();
            send_vertex(pick_vertex(), 1'b0, '0, '0);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d vertices and %0d neighbor transfers over %0d size writes",
               vertices_sent, neighbors_checked, size_writes);
      $display("boundary cases reached: %0d of 27, mismatches: %0d",
               $countones(keys_seen), errors);
      if (errors == 0 && neighbors_due.size() == 0) begin
         $display("grid_vertex_neighbor_gen verification clean");
      end else begin
         $display("grid_vertex_neighbor_gen verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
design/gvng_pkg.sv
design/gvng_divider.sv
design/gvng_datapath.sv
design/gvng_ctrl.sv
design/grid_vertex_neighbor_gen.sv
design/gvng_checker.sv
tb/grid_vertex_neighbor_gen_tb.sv
